@@ rtl/core/cdps_pkg.sv @@
`timescale 1ns / 1ps

package cdps_pkg;

   // Request as it arrives from the fieldbus side
   typedef struct packed {
      logic [15:0]       status_word;
      logic signed [7:0] displayed_mode;
      logic [1:0]        requested_state;
      logic              fault_reset_request;
      logic              halt_level;
      logic [3:0]        mode_bits;
      logic [4:0]        maker_bits;
   } req_type;

   // Result handed back to the master
   typedef struct packed {
      logic [15:0] control_word;
      logic [2:0]  power_state;
      logic        fault_flag;
      logic        warning_flag;
      logic        remote_flag;
      logic        limit_flag;
      logic [6:0]  mode_code;
   } rsp_type;

   typedef enum logic [2:0] {
      PS_NOT_READY      = 3'd0,
      PS_DISABLED       = 3'd1,
      PS_READY          = 3'd2,
      PS_SWITCHED_ON    = 3'd3,
      PS_ENABLED        = 3'd4,
      PS_QUICKSTOP      = 3'd5,
      PS_FAULT_REACTION = 3'd6,
      PS_FAULT          = 3'd7
   } power_state_type;

   typedef enum logic [1:0] {
      REQ_NONE      = 2'd0,
      REQ_READY     = 2'd1,
      REQ_ENABLE    = 2'd2,
      REQ_QUICKSTOP = 2'd3
   } power_req_type;

   // Power control bits 3..0 of the control word
   localparam logic [3:0] PWR_SHUTDOWN  = 4'b0110;
   localparam logic [3:0] PWR_OFF       = 4'b0000;
   localparam logic [3:0] PWR_ENABLE    = 4'b1111;
   localparam logic [3:0] PWR_SWITCH_ON = 4'b0111;
   localparam logic [3:0] PWR_QUICKSTOP = 4'b1011;

   localparam logic [6:0] MODE_UNKNOWN  = 7'd127;
   localparam logic [7:0] MODE_MAX      = 8'd11;
   localparam logic [7:0] MODE_RESERVED = 8'd5;

   // Status word decode passed from decoder to control word builder
   typedef struct packed {
      power_state_type state;
      logic            fault_flag;
      logic            warning_flag;
      logic            remote_flag;
      logic            limit_flag;
      logic [6:0]      mode_code;
   } status_info_type;

endpackage

@@ rtl/core/cdps_decode.sv @@
`timescale 1ns / 1ps

module cdps_decode (
   input  cdps_pkg::req_type         req,
   output cdps_pkg::status_info_type info
);
   import cdps_pkg::*;

   logic [15:0] sw;
   logic [7:0]  mode_raw;

   assign sw       = req.status_word;
   assign mode_raw = req.displayed_mode;

   // Test order matters: fault first, then quickstop, then enable
   always_comb begin
      info.fault_flag   = sw[3];
      info.warning_flag = sw[7];
      info.remote_flag  = sw[9];
      info.limit_flag   = sw[11];

      // Negative bytes read as large unsigned values and fall out as unknown
      info.mode_code = ((mode_raw <= MODE_MAX) && (mode_raw != MODE_RESERVED))
                       ? mode_raw[6:0] : MODE_UNKNOWN;

      priority if (sw[0]) begin
         priority if (sw[3])  info.state = PS_FAULT_REACTION;
         else if (!sw[5])     info.state = PS_QUICKSTOP;
         else if (sw[2])      info.state = PS_ENABLED;
         else if (sw[1])      info.state = PS_SWITCHED_ON;
         else                 info.state = PS_READY;
      end else begin
         priority if (sw[3])  info.state = PS_FAULT;
         else if (sw[6])      info.state = PS_DISABLED;
         else                 info.state = PS_NOT_READY;
      end
   end

endmodule

@@ rtl/core/cdps_ctrl.sv @@
`timescale 1ns / 1ps

module cdps_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  cdps_pkg::req_type         req,
   input  cdps_pkg::status_info_type info,
   output logic [15:0]               control_word
);
   import cdps_pkg::*;

   logic [3:0] power_bits_ff;
   logic [3:0] power_bits_in;
   logic       reset_pending_ff;
   logic       reset_pending_in;
   logic       last_reset_bit_ff;
   logic       reset_bit;
   logic       pending_now;

   // Transition rules; no matching rule keeps the previous bits
   always_comb begin
      power_bits_in = power_bits_ff;
      unique case (power_req_type'(req.requested_state))
         REQ_NONE: begin
            power_bits_in = power_bits_ff;
         end
         REQ_READY: begin
            priority if (info.state == PS_ENABLED || info.state == PS_SWITCHED_ON ||
                         info.state == PS_DISABLED)
               power_bits_in = PWR_SHUTDOWN;
            else if (info.state == PS_QUICKSTOP)
               power_bits_in = PWR_OFF;
            else
               power_bits_in = power_bits_ff;
         end
         REQ_ENABLE: begin
            priority if (info.state == PS_SWITCHED_ON || info.state == PS_QUICKSTOP)
               power_bits_in = PWR_ENABLE;
            else if (info.state == PS_READY)
               power_bits_in = PWR_SWITCH_ON;
            else if (info.state == PS_DISABLED)
               power_bits_in = PWR_SHUTDOWN;
            else
               power_bits_in = power_bits_ff;
         end
         REQ_QUICKSTOP: begin
            if (info.state == PS_ENABLED || info.state == PS_QUICKSTOP)
               power_bits_in = PWR_QUICKSTOP;
            else
               power_bits_in = PWR_OFF;
         end
         default: begin
            power_bits_in = power_bits_ff;
         end
      endcase
   end

   // Fault reset only rises on a word whose predecessor had bit 7 low
   assign pending_now      = reset_pending_ff | req.fault_reset_request;
   assign reset_bit        = pending_now & ~last_reset_bit_ff;
   assign reset_pending_in = pending_now & ~reset_bit;

   assign control_word = {req.maker_bits, 1'b0, req.mode_bits[3], req.halt_level,
                          reset_bit, req.mode_bits[2:0], power_bits_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         power_bits_ff     <= '0;
         reset_pending_ff  <= 1'b0;
         last_reset_bit_ff <= 1'b0;
      end else if (advance) begin
         power_bits_ff     <= power_bits_in;
         reset_pending_ff  <= reset_pending_in;
         last_reset_bit_ff <= reset_bit;
      end
   end

endmodule

@@ rtl/core/cia402_drive_power_sequencer.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_*     in         req_valid / req_ready  cdps_pkg::req_type
// rsp_*     out        rsp_valid / rsp_ready  cdps_pkg::rsp_type
//
// A request passes the input register, then the result register, with only
// status decode and table choice between them; the result register loads
// when it is empty or being drained. One request per clock is sustained
// while results are taken; the input register refills while a finished
// result waits, and stalls only when both are full and none is taken.
// Synchronous reset clears valids, power bits and fault-reset tracking.

module cia402_drive_power_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdps_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdps_pkg::rsp_type rsp_payload
);
   import cdps_pkg::*;

   req_type         req_ff;
   logic            req_valid_ff;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;
   logic            rsp_valid_ff;
   logic            advance;
   status_info_type info;
   logic [15:0]     control_word;

   // Request moves on when the result register is empty or being drained
   assign advance   = req_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~req_valid_ff | advance;

   cdps_decode u_decode (
      .req  (req_ff),
      .info (info)
   );

   // Sequencer state only steps when a request actually reaches the result
   cdps_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req          (req_ff),
      .info         (info),
      .control_word (control_word)
   );

   assign rsp_in.control_word = control_word;
   assign rsp_in.power_state  = info.state;
   assign rsp_in.fault_flag   = info.fault_flag;
   assign rsp_in.warning_flag = info.warning_flag;
   assign rsp_in.remote_flag  = info.remote_flag;
   assign rsp_in.limit_flag   = info.limit_flag;
   assign rsp_in.mode_code    = info.mode_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
